### src/bfs_redundant_edge_counter_top_defines.svh
// assertion macros for the checker file
`ifndef BFS_REDUNDANT_EDGE_COUNTER_TOP_DEFINES_SVH
`define BFS_REDUNDANT_EDGE_COUNTER_TOP_DEFINES_SVH

// same-cycle implication, off while reset is low
`define BFSREC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfsrec check failed");

// next-cycle implication, off while reset is low
`define BFSREC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfsrec check failed");

// next-cycle implication that also covers reset
`define BFSREC_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bfsrec check failed");

`endif

### src/bfsrec_pkg.sv
// shared constants and sequencer states for the redundant edge counter
package bfsrec_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 4096;
  localparam int END_W            = 11;
  localparam int TOTAL_W          = 13;
  localparam int CFG_W            = 11;
  localparam int CNT_W            = 2;

  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LD_A, ST_LD_B,
    ST_INIT, ST_SEED,
    ST_B_POP, ST_B_HEAD, ST_B_LOAD, ST_B_LINK, ST_B_TGT, ST_B_CHK,
    ST_C_VRD, ST_C_VLOAD, ST_C_LINK, ST_C_TGT, ST_C_CMP,
    ST_E_RD, ST_E_A, ST_E_B, ST_E_DEC,
    ST_DONE
  } bfsrec_state_t;

endpackage

### src/bfs_redundant_edge_counter_top.sv
// top level: edge loader, breadth-first search and edge tally sequencer
//
//  channel | handshake          | word
//  --------+--------------------+-------------------------------------
//  in      | start / busy       | in_kind, in_end_a, in_end_b
//  out     | out_valid strobe   | out_edge_total
//  cfg     | cfg_valid / ready  | cfg_vertex_count
//
// a stored edge keeps busy high through ST_LD_A and ST_LD_B; a dropped edge does not raise it
// a finish sets levels, runs the search over reached vertices and adjacency entries,
// runs the count pass over every vertex and its entries, tallies the stored edges,
// then shows the result and clears the list heads again
// after reset the list heads are cleared, one per vertex, with busy high
// the result is shown for one cycle; the receiver cannot stall it
module bfs_redundant_edge_counter_top #(
  parameter int MAX_VERTICES = bfsrec_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = bfsrec_pkg::MAX_EDGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic [bfsrec_pkg::END_W-1:0]    in_end_a,
  input  logic [bfsrec_pkg::END_W-1:0]    in_end_b,
  output logic                            out_valid,
  output logic [bfsrec_pkg::TOTAL_W-1:0]  out_edge_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfsrec_pkg::CFG_W-1:0]    cfg_vertex_count
);

  import bfsrec_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = VW + 1;
  localparam int LVW = VW + 1;
  localparam int VIW = LVW + 2 * CNT_W;
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int SW  = $clog2(2 * MAX_EDGES);
  localparam int LW  = $clog2(2 * MAX_EDGES + 1);
  localparam int QW  = VW + LVW;

  bfsrec_state_t state_r, state_nxt;

  logic [CFG_W-1:0] vc_r, vc_nxt;
  logic [ECW-1:0]   cnt_r, cnt_nxt;
  logic [ECW-1:0]   i_r, i_nxt;
  logic [ECW-1:0]   tally_r, tally_nxt;
  logic [VW-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic             same_r, same_nxt;
  logic [VW-1:0]    v_r, v_nxt;
  logic [NW-1:0]    qh_r, qh_nxt, qt_r, qt_nxt;
  logic [LW-1:0]    l_r, l_nxt;
  logic [VW-1:0]    t_r, t_nxt;
  logic [LVW-1:0]   cur_lvl_r, cur_lvl_nxt;
  logic [LVW-1:0]   lv_r, lv_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt, cc_r, cc_nxt;
  logic [VIW-1:0]   va_r, va_nxt;

  // memory ports
  logic          head_we;
  logic [VW-1:0] head_wa, head_ra;
  logic [LW-1:0] head_wd, head_rd;
  logic          next_we;
  logic [SW-1:0] next_wa, next_ra;
  logic [LW-1:0] next_wd, next_rd;
  logic           edge_we;
  logic [EIW-1:0] edge_wa, edge_ra;
  logic [2*VW-1:0] edge_wd, edge_rd;
  logic           vi_we;
  logic [VW-1:0]  vi_wa, vi_ra;
  logic [VIW-1:0] vi_wd, vi_rd;
  logic           q_we;
  logic [VW-1:0]  q_wa, q_ra;
  logic [QW-1:0]  q_wd, q_rd;

  // decoded helpers
  logic            accept;
  logic            edge_ok;
  logic [VW-1:0]   in_a_idx, in_b_idx;
  logic [NW-1:0]   n_v;
  logic [VW-1:0]   n_last;
  logic [SW-1:0]   slot;
  logic [VW-1:0]   tgt;
  logic            tgt_in;
  logic [VW-1:0]   ea, eb;
  logic            ends_in;
  logic signed [LVW-1:0] lt_s, lv_s, la_s, lb_s, lnear_s, lfar_s;
  logic signed [LVW:0]   lv_m1, lnear_p1;
  logic            swap;
  logic [CNT_W-1:0] fcc, fpc;
  logic            count_it;

  assign accept  = start && !busy;
  assign in_a_idx = VW'(in_end_a - END_W'(1));
  assign in_b_idx = VW'(in_end_b - END_W'(1));
  assign edge_ok = (in_end_a != '0) && (32'(in_end_a) <= MAX_VERTICES) &&
                   (in_end_b != '0) && (32'(in_end_b) <= MAX_VERTICES) &&
                   (32'(cnt_r) < MAX_EDGES);

  // clamped vertex count
  always_comb begin
    if (vc_r == '0) begin
      n_v = NW'(1);
    end else if (32'(vc_r) > MAX_VERTICES) begin
      n_v = NW'(MAX_VERTICES);
    end else begin
      n_v = NW'(vc_r);
    end
  end
  assign n_last = VW'(n_v - NW'(1));

  // adjacency entry decode: even slot points at end b, odd slot at end a
  assign slot   = SW'(l_r - LW'(1));
  assign tgt    = slot[0] ? edge_rd[2*VW-1:VW] : edge_rd[VW-1:0];
  assign tgt_in = {1'b0, tgt} < n_v;
  assign ea     = edge_rd[2*VW-1:VW];
  assign eb     = edge_rd[VW-1:0];
  assign ends_in = ({1'b0, ea} < n_v) && ({1'b0, eb} < n_v);

  // level compares
  assign lt_s  = $signed(vi_rd[VIW-1:2*CNT_W]);
  assign lv_s  = $signed(lv_r);
  assign lv_m1 = $signed({lv_r[LVW-1], lv_r}) - $signed((LVW+1)'(1));
  assign la_s  = $signed(va_r[VIW-1:2*CNT_W]);
  assign lb_s  = lt_s;
  assign swap  = la_s > lb_s;
  assign lnear_s = swap ? lb_s : la_s;
  assign lfar_s  = swap ? la_s : lb_s;
  assign lnear_p1 = $signed({lnear_s[LVW-1], lnear_s}) + $signed((LVW+1)'(1));
  assign fcc = swap ? va_r[2*CNT_W-1:CNT_W] : vi_rd[2*CNT_W-1:CNT_W];
  assign fpc = swap ? va_r[CNT_W-1:0] : vi_rd[CNT_W-1:0];
  assign count_it = ($signed({lfar_s[LVW-1], lfar_s}) != lnear_p1) ||
                    (fcc > CNT_W'(1)) || (fpc > CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (v_r == VW'(MAX_VERTICES - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_FINISH) begin
            state_nxt = ST_INIT;
          end else if (edge_ok) begin
            state_nxt = ST_LD_A;
          end
        end
      end
      ST_LD_A:    state_nxt = ST_LD_B;
      ST_LD_B:    state_nxt = ST_IDLE;
      ST_INIT:    if (v_r == n_last) state_nxt = ST_SEED;
      ST_SEED:    state_nxt = ST_B_POP;
      ST_B_POP:   state_nxt = (qh_r == qt_r) ? ST_C_VRD : ST_B_HEAD;
      ST_B_HEAD:  state_nxt = ST_B_LOAD;
      ST_B_LOAD:  state_nxt = ST_B_LINK;
      ST_B_LINK:  state_nxt = (l_r == '0) ? ST_B_POP : ST_B_TGT;
      ST_B_TGT:   state_nxt = tgt_in ? ST_B_CHK : ST_B_LINK;
      ST_B_CHK:   state_nxt = ST_B_LINK;
      ST_C_VRD:   state_nxt = ST_C_VLOAD;
      ST_C_VLOAD: state_nxt = ST_C_LINK;
      ST_C_LINK: begin
        if (l_r != '0) begin
          state_nxt = ST_C_TGT;
        end else begin
          state_nxt = (v_r == n_last) ? ST_E_RD : ST_C_VRD;
        end
      end
      ST_C_TGT:   state_nxt = tgt_in ? ST_C_CMP : ST_C_LINK;
      ST_C_CMP:   state_nxt = ST_C_LINK;
      ST_E_RD:    state_nxt = (i_r == cnt_r) ? ST_DONE : ST_E_A;
      ST_E_A:     state_nxt = ends_in ? ST_E_B : ST_E_RD;
      ST_E_B:     state_nxt = ST_E_DEC;
      ST_E_DEC:   state_nxt = ST_E_RD;
      ST_DONE:    state_nxt = ST_CLEAR;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    cfg_ready = 1'b1;
    head_we = 1'b0; head_wa = v_r; head_wd = '0; head_ra = in_a_idx;
    next_we = 1'b0; next_wa = SW'({cnt_r, 1'b0}); next_wd = head_rd; next_ra = slot;
    edge_we = 1'b0; edge_wa = EIW'(cnt_r); edge_wd = {a_r, b_r};
    edge_ra = EIW'(slot >> 1);
    vi_we = 1'b0; vi_wa = v_r; vi_wd = '0; vi_ra = tgt;
    q_we = 1'b0; q_wa = qt_r[VW-1:0]; q_wd = '0; q_ra = qh_r[VW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        head_we = 1'b1;
      end
      ST_LD_A: begin
        next_we = 1'b1;
        head_we = 1'b1; head_wa = a_r; head_wd = LW'({cnt_r, 1'b1});
        head_ra = b_r;
      end
      ST_LD_B: begin
        next_we = 1'b1; next_wa = SW'({cnt_r, 1'b1});
        next_wd = same_r ? LW'({cnt_r, 1'b1}) : head_rd;
        head_we = 1'b1; head_wa = b_r; head_wd = LW'({cnt_r, 1'b1}) + LW'(1);
        edge_we = 1'b1;
      end
      ST_INIT: begin
        vi_we = 1'b1; vi_wd = {{LVW{1'b1}}, {(2*CNT_W){1'b0}}};
      end
      ST_SEED: begin
        vi_we = 1'b1; vi_wa = '0; vi_wd = '0;
        q_we = 1'b1; q_wa = '0; q_wd = '0;
      end
      ST_B_HEAD: begin
        head_ra = q_rd[QW-1:LVW];
      end
      ST_B_CHK: begin
        if (lt_s < 0) begin
          vi_we = 1'b1; vi_wa = t_r;
          vi_wd = {cur_lvl_r + LVW'(1), {(2*CNT_W){1'b0}}};
          q_we = 1'b1; q_wd = {t_r, cur_lvl_r + LVW'(1)};
        end
      end
      ST_C_VRD: begin
        head_ra = v_r; vi_ra = v_r;
      end
      ST_C_LINK: begin
        if (l_r == '0) begin
          vi_we = 1'b1; vi_wd = {lv_r, cc_r, pc_r};
        end
      end
      ST_E_RD: begin
        edge_ra = EIW'(i_r);
      end
      ST_E_A: begin
        vi_ra = ea;
      end
      ST_E_B: begin
        vi_ra = b_r;
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    vc_nxt = cfg_valid ? cfg_vertex_count : vc_r;
    cnt_nxt = cnt_r; i_nxt = i_r; tally_nxt = tally_r;
    a_nxt = a_r; b_nxt = b_r; same_nxt = same_r;
    v_nxt = v_r; qh_nxt = qh_r; qt_nxt = qt_r;
    l_nxt = l_r; t_nxt = t_r; cur_lvl_nxt = cur_lvl_r; lv_nxt = lv_r;
    pc_nxt = pc_r; cc_nxt = cc_r; va_nxt = va_r;
    case (state_r)
      ST_CLEAR: begin
        v_nxt = v_r + VW'(1);
        cnt_nxt = '0;
      end
      ST_IDLE: begin
        a_nxt = in_a_idx; b_nxt = in_b_idx; same_nxt = (in_a_idx == in_b_idx);
        v_nxt = '0;
      end
      ST_LD_B: begin
        cnt_nxt = cnt_r + ECW'(1);
      end
      ST_INIT: begin
        v_nxt = v_r + VW'(1);
      end
      ST_SEED: begin
        qh_nxt = '0; qt_nxt = NW'(1); v_nxt = '0;
      end
      ST_B_POP: begin
        if (qh_r != qt_r) qh_nxt = qh_r + NW'(1);
      end
      ST_B_HEAD: begin
        cur_lvl_nxt = q_rd[LVW-1:0];
      end
      ST_B_LOAD, ST_C_VLOAD: begin
        l_nxt = head_rd;
        lv_nxt = vi_rd[VIW-1:2*CNT_W];
        pc_nxt = '0; cc_nxt = '0;
      end
      ST_B_TGT, ST_C_TGT: begin
        t_nxt = tgt; l_nxt = next_rd;
      end
      ST_B_CHK: begin
        if (lt_s < 0) qt_nxt = qt_r + NW'(1);
      end
      ST_C_LINK: begin
        if (l_r == '0) begin
          v_nxt = v_r + VW'(1);
          i_nxt = '0; tally_nxt = '0;
        end
      end
      ST_C_CMP: begin
        if (lt_s <= lv_s && pc_r != CNT_W'(2)) pc_nxt = pc_r + CNT_W'(1);
        if ($signed({lt_s[LVW-1], lt_s}) == lv_m1 && cc_r != CNT_W'(2)) begin
          cc_nxt = cc_r + CNT_W'(1);
        end
      end
      ST_E_A: begin
        b_nxt = eb;
        if (!ends_in) i_nxt = i_r + ECW'(1);
      end
      ST_E_B: begin
        va_nxt = vi_rd;
      end
      ST_E_DEC: begin
        i_nxt = i_r + ECW'(1);
        if (count_it) tally_nxt = tally_r + ECW'(1);
      end
      ST_DONE: begin
        v_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign out_edge_total = TOTAL_W'(tally_r);

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      vc_r    <= CFG_W'(1);
      cnt_r   <= '0;
      i_r     <= '0;
      tally_r <= '0;
      v_r     <= '0;
      qh_r    <= '0;
      qt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      vc_r    <= vc_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      tally_r <= tally_nxt;
      v_r     <= v_nxt;
      qh_r    <= qh_nxt;
      qt_r    <= qt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; same_r <= same_nxt;
    l_r <= l_nxt; t_r <= t_nxt; cur_lvl_r <= cur_lvl_nxt; lv_r <= lv_nxt;
    pc_r <= pc_nxt; cc_r <= cc_nxt; va_r <= va_nxt;
  end

  // list heads, one per vertex
  bfsrec_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES), .AW(VW)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(head_ra), .rdata(head_rd)
  );

  // adjacency links, two per edge
  bfsrec_ram #(.WIDTH(LW), .DEPTH(2 * MAX_EDGES), .AW(SW)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(next_ra), .rdata(next_rd)
  );

  // edge records, also give adjacency targets
  bfsrec_ram #(.WIDTH(2 * VW), .DEPTH(MAX_EDGES), .AW(EIW)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd),
    .raddr(edge_ra), .rdata(edge_rd)
  );

  // per-vertex level and saturating counts
  bfsrec_ram #(.WIDTH(VIW), .DEPTH(MAX_VERTICES), .AW(VW)) u_vinfo (
    .clk(clk), .we(vi_we), .waddr(vi_wa), .wdata(vi_wd),
    .raddr(vi_ra), .rdata(vi_rd)
  );

  // visit queue of vertex and level
  bfsrec_ram #(.WIDTH(QW), .DEPTH(MAX_VERTICES), .AW(VW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .raddr(q_ra), .rdata(q_rd)
  );

endmodule

### src/bfsrec_ram.sv
// simple dual-port ram, one write and one registered read per cycle
module bfsrec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/bfsrec_chk.sv
// port-level checker for the redundant edge counter, bound to the top level
`include "bfs_redundant_edge_counter_top_defines.svh"

module bfsrec_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_kind,
  input logic out_valid
);

  import bfsrec_pkg::*;

  // result strobe lasts one cycle
  `BFSREC_ASSERT_NXT(a_strobe_once, out_valid, !out_valid)
  // result only shows while busy
  `BFSREC_ASSERT_NOW(a_result_busy, out_valid, busy)
  // a finish word starts the computation
  `BFSREC_ASSERT_NXT(a_finish_busy, start && !busy && in_kind == KIND_FINISH, busy)
  // reset leads into the head clearing pass
  `BFSREC_ASSERT_ALWAYS(a_reset_clear, !rst_n, busy && !out_valid)

endmodule

bind bfs_redundant_edge_counter_top bfsrec_chk u_bfsrec_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_kind(in_kind), .out_valid(out_valid)
);
